[src/pgpu_pkg.sv]
// ----------------------------------------------------------------------------
// pgpu_pkg
// Shared types and constants for the ground-plane back-projection pipeline.
// ----------------------------------------------------------------------------
package pgpu_pkg;

	localparam int ROW_BITS = 63;
	localparam int POS_BITS = 32;
	localparam int CAM_BITS = 8;
	localparam int H_BITS   = POS_BITS + 1;
	localparam int QB       = 40;

	localparam logic [2:0] REG_ROW_X  = 3'd0;
	localparam logic [2:0] REG_ROW_Y  = 3'd1;
	localparam logic [2:0] REG_ROW_Z  = 3'd2;
	localparam logic [2:0] REG_CAM_X  = 3'd3;
	localparam logic [2:0] REG_CAM_Y  = 3'd4;
	localparam logic [2:0] REG_CAM_Z  = 3'd5;
	localparam logic [2:0] REG_GROUND = 3'd6;
	localparam logic [2:0] REG_OWN    = 3'd7;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_PAR = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic [7:0]  blob;
		logic [31:0] tstamp;
		logic        par;
		logic        neg_x;
		logic        neg_y;
		logic        big_x;
		logic        big_y;
	} meta_t;

endpackage

[src/pgpu_if.sv]
// ----------------------------------------------------------------------------
// pgpu_in_if / pgpu_out_if
// Valid/ready channels for pixel transactions and ground-plane results.
// ----------------------------------------------------------------------------
interface pgpu_in_if #(parameter int PIXEL_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_u;
	logic [PIXEL_BITS-1:0] pixel_v;
	logic [7:0]            source_camera;
	logic [7:0]            blob_number;
	logic [31:0]           time_tag;

	modport source (output valid, pixel_u, pixel_v, source_camera, blob_number, time_tag,
		input ready);
	modport sink (input valid, pixel_u, pixel_v, source_camera, blob_number, time_tag,
		output ready);
endinterface

interface pgpu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	logic [7:0]         camera_out;
	logic [7:0]         blob_out;
	logic [31:0]        time_out;
	logic [1:0]         status;

	modport source (output valid, world_x, world_y, world_z, camera_out, blob_out, time_out,
		status, input ready);
	modport sink (input valid, world_x, world_y, world_z, camera_out, blob_out, time_out,
		status, output ready);
endinterface

[src/pixel_ground_plane_unproject_unit.sv]
// ----------------------------------------------------------------------------
// pixel_ground_plane_unproject_unit
// Pipeline: ray and multiply stages, the 41-stage divider, then output stages.
// Throughput: one transaction per cycle; the whole pipeline holds on a stall.
// Reset clears valid bits and configuration registers to zero.
// ----------------------------------------------------------------------------
module pixel_ground_plane_unproject_unit import pgpu_pkg::*; #(
	parameter int PIXEL_BITS = 10,
	parameter int COEF_BITS  = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [ROW_BITS-1:0] cfg_wdata,
	pgpu_in_if.sink             pixel,
	pgpu_out_if.source          result
);

	localparam int DW  = COEF_BITS + PIXEL_BITS + 3;
	localparam int PRW = H_BITS + DW;
	localparam int RW  = DW + 1;

	logic [ROW_BITS-1:0]        row_q [3];
	logic signed [POS_BITS-1:0] cam_q [2];
	logic signed [POS_BITS-1:0] cam_z_q, ground_q;
	logic [CAM_BITS-1:0]        own_q;

	logic                 en;
	logic                 in_vld;
	meta_t                meta_in;
	logic                 ray_vld;
	logic signed [DW-1:0] ray_d [3];
	meta_t                ray_meta;
	logic                 mul_vld;
	logic [PRW-1:0]       mul_p [2];
	logic [DW-1:0]        mul_den;
	meta_t                mul_meta;
	logic                 div_vld;
	logic [QB-1:0]        div_q [2];
	logic [RW-1:0]        div_rem [2];
	logic [DW-1:0]        div_den;
	meta_t                div_meta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '{default: '0};
			cam_q    <= '{default: '0};
			cam_z_q  <= '0;
			ground_q <= '0;
			own_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROW_X:  row_q[0] <= cfg_wdata;
				REG_ROW_Y:  row_q[1] <= cfg_wdata;
				REG_ROW_Z:  row_q[2] <= cfg_wdata;
				REG_CAM_X:  cam_q[0] <= cfg_wdata[POS_BITS-1:0];
				REG_CAM_Y:  cam_q[1] <= cfg_wdata[POS_BITS-1:0];
				REG_CAM_Z:  cam_z_q  <= cfg_wdata[POS_BITS-1:0];
				REG_GROUND: ground_q <= cfg_wdata[POS_BITS-1:0];
				REG_OWN:    own_q    <= cfg_wdata[CAM_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign en          = !result.valid || result.ready;
	assign pixel.ready = en;
	assign in_vld      = pixel.valid && (pixel.source_camera == own_q);

	always_comb begin
		meta_in        = '0;
		meta_in.blob   = pixel.blob_number;
		meta_in.tstamp = pixel.time_tag;
	end

	pgpu_ray #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS), .DW(DW)) u_ray (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_vld),
		.u_i(pixel.pixel_u), .v_i(pixel.pixel_v), .row_i(row_q), .meta_i(meta_in),
		.vld_o(ray_vld), .d_o(ray_d), .meta_o(ray_meta)
	);

	pgpu_mul #(.DW(DW), .PRW(PRW)) u_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(ray_vld), .d_i(ray_d),
		.meta_i(ray_meta), .gh_i(ground_q), .cz_i(cam_z_q),
		.vld_o(mul_vld), .p_o(mul_p), .den_o(mul_den), .meta_o(mul_meta)
	);

	pgpu_div #(.DW(DW), .PRW(PRW), .RW(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(mul_vld), .p_i(mul_p),
		.den_i(mul_den), .meta_i(mul_meta),
		.vld_o(div_vld), .q_o(div_q), .rem_o(div_rem), .den_o(div_den), .meta_o(div_meta)
	);

	pgpu_out #(.DW(DW), .RW(RW)) u_out (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(div_vld), .q_i(div_q),
		.rem_i(div_rem), .den_i(div_den), .meta_i(div_meta), .cam_i(cam_q),
		.gh_i(ground_q), .own_i(own_q),
		.vld_o(result.valid), .wx_o(result.world_x), .wy_o(result.world_y),
		.wz_o(result.world_z), .cam_o(result.camera_out), .blob_o(result.blob_out),
		.time_o(result.time_out), .status_o(result.status)
	);

endmodule

[src/pgpu_ray.sv]
// ----------------------------------------------------------------------------
// pgpu_ray
// Ray direction d = M*(u,v,1): coefficient products, then row sums.
// ----------------------------------------------------------------------------
module pgpu_ray import pgpu_pkg::*; #(
	parameter int PIXEL_BITS = 10,
	parameter int COEF_BITS  = 21,
	parameter int DW         = COEF_BITS + PIXEL_BITS + 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  logic [PIXEL_BITS-1:0] u_i,
	input  logic [PIXEL_BITS-1:0] v_i,
	input  logic [ROW_BITS-1:0]   row_i [3],
	input  meta_t                 meta_i,
	output logic                  vld_o,
	output logic signed [DW-1:0]  d_o [3],
	output meta_t                 meta_o
);

	localparam int PW = COEF_BITS + PIXEL_BITS + 1;

	logic                        vld_s1, vld_s2;
	meta_t                       meta_s1, meta_s2;
	logic signed [PW-1:0]        pu_s1 [3];
	logic signed [PW-1:0]        pv_s1 [3];
	logic signed [COEF_BITS-1:0] c_s1 [3];
	logic signed [DW-1:0]        d_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_i;
			meta_s2 <= meta_s1;
			for (int r = 0; r < 3; r++) begin
				pu_s1[r] <= $signed(row_i[r][0 +: COEF_BITS]) * $signed({1'b0, u_i});
				pv_s1[r] <= $signed(row_i[r][COEF_BITS +: COEF_BITS]) * $signed({1'b0, v_i});
				c_s1[r]  <= $signed(row_i[r][2*COEF_BITS +: COEF_BITS]);
				d_s2[r]  <= DW'(pu_s1[r]) + DW'(pv_s1[r]) + DW'(c_s1[r]);
			end
		end
	end

	assign vld_o  = vld_s2;
	assign d_o    = d_s2;
	assign meta_o = meta_s2;

endmodule

[src/pgpu_mul.sv]
// ----------------------------------------------------------------------------
// pgpu_mul
// Height difference times the x and y ray components, in two partial products each.
// ----------------------------------------------------------------------------
module pgpu_mul import pgpu_pkg::*; #(
	parameter int DW  = 34,
	parameter int PRW = H_BITS + DW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic signed [DW-1:0]       d_i [3],
	input  meta_t                      meta_i,
	input  logic signed [POS_BITS-1:0] gh_i,
	input  logic signed [POS_BITS-1:0] cz_i,
	output logic                       vld_o,
	output logic [PRW-1:0]             p_o [2],
	output logic [DW-1:0]              den_o,
	output meta_t                      meta_o
);

	localparam int HL = DW / 2;
	localparam int HH = DW - HL;

	logic signed [H_BITS-1:0] h;
	meta_t                    m3;

	logic                  vld_s3, vld_s4, vld_s5;
	meta_t                 meta_s3, meta_s4, meta_s5;
	logic [H_BITS-1:0]     hm_s3;
	logic [DW-1:0]         am_s3 [3];
	logic [H_BITS+HL-1:0]  ppl_s4 [2];
	logic [H_BITS+HH-1:0]  pph_s4 [2];
	logic [DW-1:0]         den_s4, den_s5;
	logic [PRW-1:0]        p_s5 [2];

	assign h = H_BITS'(gh_i) - H_BITS'(cz_i);

	always_comb begin
		m3       = meta_i;
		m3.par   = (d_i[2] == '0);
		m3.neg_x = h[H_BITS-1] ^ d_i[0][DW-1] ^ d_i[2][DW-1];
		m3.neg_y = h[H_BITS-1] ^ d_i[1][DW-1] ^ d_i[2][DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_i;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3 <= m3;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			hm_s3   <= h[H_BITS-1] ? H_BITS'(-h) : H_BITS'(h);
			for (int r = 0; r < 3; r++)
				am_s3[r] <= d_i[r][DW-1] ? DW'(-d_i[r]) : DW'(d_i[r]);
			for (int c = 0; c < 2; c++) begin
				ppl_s4[c] <= (H_BITS+HL)'(hm_s3) * (H_BITS+HL)'(am_s3[c][HL-1:0]);
				pph_s4[c] <= (H_BITS+HH)'(hm_s3) * (H_BITS+HH)'(am_s3[c][DW-1:HL]);
				p_s5[c]   <= PRW'(ppl_s4[c]) + (PRW'(pph_s4[c]) << HL);
			end
			den_s4 <= am_s3[2];
			den_s5 <= den_s4;
		end
	end

	assign vld_o  = vld_s5;
	assign p_o    = p_s5;
	assign den_o  = den_s5;
	assign meta_o = meta_s5;

endmodule

[src/pgpu_div.sv]
// ----------------------------------------------------------------------------
// pgpu_div
// Pipelined restoring divider, one quotient bit per stage, both axes.
// ----------------------------------------------------------------------------
module pgpu_div import pgpu_pkg::*; #(
	parameter int DW  = 34,
	parameter int PRW = H_BITS + DW,
	parameter int RW  = DW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [PRW-1:0] p_i [2],
	input  logic [DW-1:0]  den_i,
	input  meta_t          meta_i,
	output logic           vld_o,
	output logic [QB-1:0]  q_o [2],
	output logic [RW-1:0]  rem_o [2],
	output logic [DW-1:0]  den_o,
	output meta_t          meta_o
);

	logic [RW-1:0] r0 [2];
	meta_t         m0;

	logic          vld_s  [QB+1];
	meta_t         meta_s [QB+1];
	logic [DW-1:0] den_s  [QB+1];
	logic [RW-1:0] rem_s  [QB+1][2];
	logic [QB-1:0] low_s  [QB+1][2];
	logic [QB-1:0] q_s    [QB+1][2];

	always_comb begin
		for (int c = 0; c < 2; c++)
			r0[c] = RW'(p_i[c][PRW-1:QB]);
		m0       = meta_i;
		m0.big_x = (r0[0] >= RW'(den_i));
		m0.big_y = (r0[1] >= RW'(den_i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= m0;
			den_s[0]  <= den_i;
			for (int c = 0; c < 2; c++) begin
				rem_s[0][c] <= r0[c];
				low_s[0][c] <= p_i[c][QB-1:0];
				q_s[0][c]   <= '0;
			end
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [RW-1:0] t  [2];
		logic          ge [2];

		always_comb begin
			for (int c = 0; c < 2; c++) begin
				t[c]  = {rem_s[k-1][c][RW-2:0], low_s[k-1][c][QB-1]};
				ge[c] = (t[c] >= {1'b0, den_s[k-1]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= meta_s[k-1];
				den_s[k]  <= den_s[k-1];
				for (int c = 0; c < 2; c++) begin
					rem_s[k][c] <= ge[c] ? t[c] - {1'b0, den_s[k-1]} : t[c];
					low_s[k][c] <= low_s[k-1][c] << 1;
					q_s[k][c]   <= {q_s[k-1][c][QB-2:0], ge[c]};
				end
			end
		end
	end

	assign vld_o  = vld_s[QB];
	assign meta_o = meta_s[QB];
	assign den_o  = den_s[QB];
	assign q_o    = q_s[QB];
	assign rem_o  = rem_s[QB];

endmodule

[src/pgpu_out.sv]
// ----------------------------------------------------------------------------
// pgpu_out
// Rounding, offset by camera position, saturation, parallel-ray zeroing and the output register.
// ----------------------------------------------------------------------------
module pgpu_out import pgpu_pkg::*; #(
	parameter int DW = 34,
	parameter int RW = DW + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [QB-1:0]              q_i [2],
	input  logic [RW-1:0]              rem_i [2],
	input  logic [DW-1:0]              den_i,
	input  meta_t                      meta_i,
	input  logic signed [POS_BITS-1:0] cam_i [2],
	input  logic signed [POS_BITS-1:0] gh_i,
	input  logic [CAM_BITS-1:0]        own_i,
	output logic                       vld_o,
	output logic signed [POS_BITS-1:0] wx_o,
	output logic signed [POS_BITS-1:0] wy_o,
	output logic signed [POS_BITS-1:0] wz_o,
	output logic [CAM_BITS-1:0]        cam_o,
	output logic [7:0]                 blob_o,
	output logic [31:0]                time_o,
	output logic [1:0]                 status_o
);

	localparam int QW = QB + 1;
	localparam int VW = QB + 3;

	logic [QW-1:0]              qr [2];
	logic                       big [2];
	logic                       neg [2];
	logic signed [VW-1:0]       val [2];
	logic                       sat_hi [2];
	logic                       sat_lo [2];
	logic signed [POS_BITS-1:0] clamp [2];

	logic                       vld_s1, vld_s2;
	meta_t                      meta_s1;
	logic [QW-1:0]              q_s1 [2];
	logic signed [POS_BITS-1:0] wx_s2, wy_s2, wz_s2;
	logic [CAM_BITS-1:0]        cam_s2;
	logic [7:0]                 blob_s2;
	logic [31:0]                time_s2;
	logic [1:0]                 status_s2;

	assign big[0] = meta_i.big_x;
	assign big[1] = meta_i.big_y;
	assign neg[0] = meta_s1.neg_x;
	assign neg[1] = meta_s1.neg_y;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (big[c])
				qr[c] = QW'(1) << QB;
			else
				qr[c] = QW'(q_i[c]) + QW'({rem_i[c], 1'b0} >= (RW+1)'(den_i));
			if (neg[c])
				val[c] = VW'(cam_i[c]) - $signed(VW'(q_s1[c]));
			else
				val[c] = VW'(cam_i[c]) + $signed(VW'(q_s1[c]));
			sat_hi[c] = !val[c][VW-1] && (|val[c][VW-2:POS_BITS-1]);
			sat_lo[c] = val[c][VW-1] && !(&val[c][VW-2:POS_BITS-1]);
			if (sat_hi[c])
				clamp[c] = {1'b0, {(POS_BITS-1){1'b1}}};
			else if (sat_lo[c])
				clamp[c] = {1'b1, {(POS_BITS-1){1'b0}}};
			else
				clamp[c] = val[c][POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_i;
			q_s1    <= qr;
			wz_s2   <= gh_i;
			cam_s2  <= own_i;
			blob_s2 <= meta_s1.blob;
			time_s2 <= meta_s1.tstamp;
			if (meta_s1.par) begin
				wx_s2     <= '0;
				wy_s2     <= '0;
				status_s2 <= ST_PAR;
			end else begin
				wx_s2     <= clamp[0];
				wy_s2     <= clamp[1];
				status_s2 <= (sat_hi[0] || sat_lo[0] || sat_hi[1] || sat_lo[1]) ? ST_SAT : ST_OK;
			end
		end
	end

	assign vld_o    = vld_s2;
	assign wx_o     = wx_s2;
	assign wy_o     = wy_s2;
	assign wz_o     = wz_s2;
	assign cam_o    = cam_s2;
	assign blob_o   = blob_s2;
	assign time_o   = time_s2;
	assign status_o = status_s2;

endmodule

[src/pgpu_chk.sv]
// ----------------------------------------------------------------------------
// pgpu_chk
// Port-level checks on the back-projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module pgpu_chk import pgpu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [31:0] world_x,
	input logic signed [31:0] world_y,
	input logic [1:0]        status
);

	localparam logic signed [31:0] MAX_POS = 32'sh7fff_ffff;
	localparam logic signed [31:0] MIN_POS = 32'sh8000_0000;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(status))
		else $error("result changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without an output stall");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_PAR |-> world_x == 0 && world_y == 0)
		else $error("parallel ray with non-zero position");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |-> world_x == MAX_POS || world_x == MIN_POS ||
			world_y == MAX_POS || world_y == MIN_POS)
		else $error("saturated status without a clamped axis");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_PAR || status == ST_SAT)
		else $error("undefined status code");

endmodule

bind pixel_ground_plane_unproject_unit pgpu_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(pixel.ready), .out_valid(result.valid),
	.out_ready(result.ready), .world_x(result.world_x), .world_y(result.world_y),
	.status(result.status)
);
